// ===== src/sfc_pkg.sv =====
// Shared types and constants for the serial frame codec with XOR checksum.
`default_nettype none
package sfc_pkg;

	// Framing bytes.
	localparam logic [7:0] START_BYTE = 8'h1B;
	localparam logic [7:0] TOKEN_BYTE = 8'h0E;

	// Input operation codes.
	localparam logic [1:0] OP_RX_BYTE  = 2'd0;
	localparam logic [1:0] OP_TX_START = 2'd1;
	localparam logic [1:0] OP_TX_BYTE  = 2'd2;

	// Result kinds.
	localparam logic [1:0] KIND_RX_DATA   = 2'd0;
	localparam logic [1:0] KIND_RX_STATUS = 2'd1;
	localparam logic [1:0] KIND_TX_LINE   = 2'd2;

	// Frame status codes.
	localparam logic [2:0] STAT_OK        = 3'd0;
	localparam logic [2:0] STAT_BAD_START = 3'd1;
	localparam logic [2:0] STAT_BAD_SEQ   = 3'd2;
	localparam logic [2:0] STAT_BAD_TOKEN = 3'd3;
	localparam logic [2:0] STAT_BAD_CHECK = 3'd4;

	// Receive parser phases.
	localparam logic [2:0] PH_START  = 3'd0;
	localparam logic [2:0] PH_SEQ    = 3'd1;
	localparam logic [2:0] PH_LEN_HI = 3'd2;
	localparam logic [2:0] PH_LEN_LO = 3'd3;
	localparam logic [2:0] PH_TOKEN  = 3'd4;
	localparam logic [2:0] PH_DATA   = 3'd5;
	localparam logic [2:0] PH_CHECK  = 3'd6;

	// Most result words that one input word can cause.
	localparam int MAX_RESULTS = 6;

	// One burst of result words caused by a single input word.
	typedef struct packed {
		logic [1:0]                  kind;
		logic [MAX_RESULTS-1:0][7:0] bytes;
		logic [2:0]                  count;
		logic [15:0]                 index;
		logic [2:0]                  status;
	} burst_t;

endpackage
`default_nettype wire

// ===== src/serial_frame_codec_xor_checksum_unit.sv =====
// Top level of the full-duplex serial frame codec with XOR checksum.
//
//   channel | handshake          | payload
//   --------+--------------------+---------------------------------------------
//   input   | in_valid/in_stall  | operation, byte_value, frame_length
//   output  | out_valid/out_stall| result_kind, out_byte, payload_index,
//           |                    | frame_status, last_of_run
//
// Each input word is decoded in the cycle it is accepted and its results
// (zero to six words) are loaded into a burst register. The burst register
// sends one result word per cycle while out_stall is low, so a word with one
// result sustains one word per cycle; a transmit start sends five or six words.
// The input is taken again in the cycle the last word of a burst leaves.
// Reset returns the parser to hunting, clears the sequence number and
// empties the burst register. An output stall holds the current word.
`default_nettype none
module serial_frame_codec_xor_checksum_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [1:0]  operation,
	input  wire  [7:0]  byte_value,
	input  wire  [15:0] frame_length,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [1:0]  result_kind,
	output logic [7:0]  out_byte,
	output logic [15:0] payload_index,
	output logic [2:0]  frame_status,
	output logic        last_of_run
);

	// Protocol state.
	logic [2:0]  rx_phase_q,     rx_phase_d;
	logic [7:0]  seq_number_q,   seq_number_d;
	logic [7:0]  rx_check_q,     rx_check_d;
	logic [15:0] rx_length_q,    rx_length_d;
	logic [15:0] rx_count_q,     rx_count_d;
	logic [7:0]  tx_check_q,     tx_check_d;
	logic [15:0] tx_remaining_q, tx_remaining_d;
	logic        tx_busy_q,      tx_busy_d;

	// Burst register and its read position.
	sfc_pkg::burst_t burst_q, burst_d;
	logic            burst_valid_q;
	logic [2:0]      pos_q;

	logic in_accept;
	logic out_accept;
	logic out_last;
	logic [7:0]  rx_check_x;
	logic [15:0] rx_count_inc;
	logic [7:0]  hdr_check;
	logic [7:0]  tx_check_x;
	logic [15:0] tx_remaining_dec;

	// Handshake: the burst register frees up when its last word leaves.
	assign out_valid  = burst_valid_q;
	assign out_last   = (pos_q == (burst_q.count - 3'd1));
	assign out_accept = out_valid && !out_stall;
	assign in_stall   = burst_valid_q && !(out_accept && out_last);
	assign in_accept  = in_valid && !in_stall;

	// Output word selection from the burst register.
	assign result_kind   = burst_q.kind;
	assign out_byte      = burst_q.bytes[pos_q];
	assign payload_index = burst_q.index;
	assign frame_status  = burst_q.status;
	assign last_of_run   = out_last;

	assign rx_check_x       = rx_check_q ^ byte_value;
	assign rx_count_inc     = rx_count_q + 16'd1;
	assign hdr_check        = sfc_pkg::START_BYTE ^ seq_number_q ^ frame_length[15:8] ^
	                          frame_length[7:0] ^ sfc_pkg::TOKEN_BYTE;
	assign tx_check_x       = tx_check_q ^ byte_value;
	assign tx_remaining_dec = tx_remaining_q - 16'd1;

	// Decode one input word into the next state and its burst of results.
	always_comb begin
		rx_phase_d     = rx_phase_q;
		seq_number_d   = seq_number_q;
		rx_check_d     = rx_check_q;
		rx_length_d    = rx_length_q;
		rx_count_d     = rx_count_q;
		tx_check_d     = tx_check_q;
		tx_remaining_d = tx_remaining_q;
		tx_busy_d      = tx_busy_q;
		burst_d        = '0;
		burst_d.bytes[0] = byte_value;

		unique case (operation)
			sfc_pkg::OP_RX_BYTE: begin
				burst_d.kind = sfc_pkg::KIND_RX_STATUS;
				rx_check_d   = rx_check_x;
				unique case (rx_phase_q)
					sfc_pkg::PH_START: begin
						rx_check_d = byte_value;
						if (byte_value != sfc_pkg::START_BYTE) begin
							burst_d.count  = 3'd1;
							burst_d.status = sfc_pkg::STAT_BAD_START;
						end else begin
							rx_phase_d = sfc_pkg::PH_SEQ;
						end
					end
					sfc_pkg::PH_SEQ: begin
						if (byte_value != seq_number_q + 8'd1) begin
							burst_d.count  = 3'd1;
							burst_d.status = sfc_pkg::STAT_BAD_SEQ;
							rx_phase_d     = sfc_pkg::PH_START;
						end else begin
							seq_number_d = byte_value;
							rx_phase_d   = sfc_pkg::PH_LEN_HI;
						end
					end
					sfc_pkg::PH_LEN_HI: begin
						rx_length_d = {byte_value, 8'h00};
						rx_phase_d  = sfc_pkg::PH_LEN_LO;
					end
					sfc_pkg::PH_LEN_LO: begin
						rx_length_d = {rx_length_q[15:8], byte_value};
						rx_phase_d  = sfc_pkg::PH_TOKEN;
					end
					sfc_pkg::PH_TOKEN: begin
						if (byte_value != sfc_pkg::TOKEN_BYTE) begin
							burst_d.count  = 3'd1;
							burst_d.status = sfc_pkg::STAT_BAD_TOKEN;
							rx_phase_d     = sfc_pkg::PH_START;
						end else begin
							rx_count_d = '0;
							rx_phase_d = (rx_length_q == 16'd0) ? sfc_pkg::PH_CHECK
							                                    : sfc_pkg::PH_DATA;
						end
					end
					sfc_pkg::PH_DATA: begin
						burst_d.kind  = sfc_pkg::KIND_RX_DATA;
						burst_d.count = 3'd1;
						burst_d.index = rx_count_q;
						rx_count_d    = rx_count_inc;
						if (rx_count_inc == rx_length_q) begin
							rx_phase_d = sfc_pkg::PH_CHECK;
						end
					end
					default: begin
						// Checksum byte, and any phase code with no meaning.
						burst_d.count  = 3'd1;
						burst_d.status = (byte_value == rx_check_q) ? sfc_pkg::STAT_OK
						                                            : sfc_pkg::STAT_BAD_CHECK;
						rx_phase_d     = sfc_pkg::PH_START;
					end
				endcase
			end
			sfc_pkg::OP_TX_START: begin
				burst_d.kind     = sfc_pkg::KIND_TX_LINE;
				burst_d.bytes[0] = sfc_pkg::START_BYTE;
				burst_d.bytes[1] = seq_number_q;
				burst_d.bytes[2] = frame_length[15:8];
				burst_d.bytes[3] = frame_length[7:0];
				burst_d.bytes[4] = sfc_pkg::TOKEN_BYTE;
				burst_d.bytes[5] = hdr_check;
				tx_check_d       = hdr_check;
				tx_remaining_d   = frame_length;
				if (frame_length == 16'd0) begin
					burst_d.count = 3'd6;
					tx_busy_d     = 1'b0;
				end else begin
					burst_d.count = 3'd5;
					tx_busy_d     = 1'b1;
				end
			end
			sfc_pkg::OP_TX_BYTE: begin
				burst_d.kind     = sfc_pkg::KIND_TX_LINE;
				burst_d.bytes[1] = tx_check_x;
				if (tx_busy_q) begin
					tx_check_d     = tx_check_x;
					tx_remaining_d = tx_remaining_dec;
					if (tx_remaining_dec == 16'd0) begin
						burst_d.count = 3'd2;
						tx_busy_d     = 1'b0;
					end else begin
						burst_d.count = 3'd1;
					end
				end
			end
			default: begin
				// Unused operation: no state change and no results.
			end
		endcase
	end

	// Protocol state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_phase_q     <= sfc_pkg::PH_START;
			seq_number_q   <= '0;
			rx_check_q     <= '0;
			rx_length_q    <= '0;
			rx_count_q     <= '0;
			tx_check_q     <= '0;
			tx_remaining_q <= '0;
			tx_busy_q      <= 1'b0;
		end else if (in_accept) begin
			rx_phase_q     <= rx_phase_d;
			seq_number_q   <= seq_number_d;
			rx_check_q     <= rx_check_d;
			rx_length_q    <= rx_length_d;
			rx_count_q     <= rx_count_d;
			tx_check_q     <= tx_check_d;
			tx_remaining_q <= tx_remaining_d;
			tx_busy_q      <= tx_busy_d;
		end
	end

	// Burst control: load on an input word with results, step on each output word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_valid_q <= 1'b0;
			pos_q         <= '0;
		end else if (in_accept && (burst_d.count != 3'd0)) begin
			burst_valid_q <= 1'b1;
			pos_q         <= '0;
		end else if (out_accept) begin
			if (out_last) begin
				burst_valid_q <= 1'b0;
			end
			pos_q <= pos_q + 3'd1;
		end
	end

	// Burst payload needs no reset.
	always_ff @(posedge clk) begin
		if (in_accept && (burst_d.count != 3'd0)) begin
			burst_q <= burst_d;
		end
	end

	// The read position always points inside the loaded burst.
	a_pos_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		burst_valid_q |-> (pos_q < burst_q.count))
		else $error("burst position beyond burst length");

	// A stalled output word keeps its place in the burst.
	a_pos_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(pos_q)))
		else $error("burst position moved under stall");

	// Only received payload words carry an index.
	a_index_only_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (result_kind != sfc_pkg::KIND_RX_DATA)) |-> (payload_index == 16'd0))
		else $error("index on a word that is not received payload");

	// A transmit frame in progress always has bytes left to send.
	a_tx_busy_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		tx_busy_q |-> (tx_remaining_q != 16'd0))
		else $error("transmit busy with no bytes remaining");

endmodule
`default_nettype wire

// ===== test/tb_serial_frame_codec_xor_checksum_unit.sv =====
// Self-checking testbench for the serial frame codec with XOR checksum.
`timescale 1ns / 1ps
module tb_serial_frame_codec_xor_checksum_unit;

	// Operation code that the block ignores.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Ways a received frame can be damaged on purpose.
	localparam int FLAW_NONE  = 0;
	localparam int FLAW_START = 1;
	localparam int FLAW_SEQ   = 2;
	localparam int FLAW_TOKEN = 3;
	localparam int FLAW_CHECK = 4;

	localparam int RANDOM_ITEMS = 170;
	localparam int STUCK_LIMIT  = 2000;

	// One result word as seen on the output ports.
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic [15:0] index;
		logic [2:0]  status;
		logic        last;
	} codec_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  operation = sfc_pkg::OP_RX_BYTE;
	logic [7:0]  byte_value = 8'h00;
	logic [15:0] frame_length = 16'h0000;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  result_kind;
	logic [7:0]  out_byte;
	logic [15:0] payload_index;
	logic [2:0]  frame_status;
	logic        last_of_run;

	// Predicted codec state.
	logic [2:0]  rx_stage = sfc_pkg::PH_START;
	logic [7:0]  seq_q = 8'h00;
	logic [7:0]  rx_sum = 8'h00;
	logic [15:0] rx_len = 16'h0000;
	logic [15:0] rx_cnt = 16'h0000;
	logic [7:0]  tx_sum = 8'h00;
	logic [15:0] tx_left = 16'h0000;
	logic        tx_open = 1'b0;

	codec_word_t codec_outputs_due[$];
	int          active_items = 0;
	int          failures = 0;
	int          stuck_cycles = 0;
	bit          steady = 1'b0;

	serial_frame_codec_xor_checksum_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.byte_value(byte_value),
		.frame_length(frame_length),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.out_byte(out_byte),
		.payload_index(payload_index),
		.frame_status(frame_status),
		.last_of_run(last_of_run)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void note_failure(input string msg);
		failures++;
		if (failures <= 10)
			$display("%s", msg);
	endfunction

	function automatic void emit_result(input logic [1:0] kind, input logic [7:0] data,
			input logic [15:0] index, input logic [2:0] status);
		codec_word_t w;
		w.kind = kind;
		w.data = data;
		w.index = index;
		w.status = status;
		w.last = 1'b0;
		codec_outputs_due.push_back(w);
	endfunction

	// A transmitted line byte also goes into the running checksum.
	function automatic void emit_tx_line(input logic [7:0] b);
		emit_result(sfc_pkg::KIND_TX_LINE, b, 16'd0, sfc_pkg::STAT_OK);
		tx_sum ^= b;
	endfunction

	// Advance the predicted codec by one accepted input word and queue its results.
	function automatic void compute_codec_outputs(input logic [1:0] op, input logic [7:0] b,
			input logic [15:0] len);
		int          queued;
		logic [7:0]  next_seq;
		codec_word_t w;
		queued = codec_outputs_due.size();
		next_seq = seq_q + 8'd1;
		if (op != OP_UNUSED && !(op == sfc_pkg::OP_TX_BYTE && !tx_open))
			active_items++;
		case (op)
			sfc_pkg::OP_RX_BYTE: begin
				case (rx_stage)
					sfc_pkg::PH_START: begin
						rx_sum = b;
						if (b == sfc_pkg::START_BYTE)
							rx_stage = sfc_pkg::PH_SEQ;
						else
							emit_result(sfc_pkg::KIND_RX_STATUS, b, 16'd0,
								sfc_pkg::STAT_BAD_START);
					end
					sfc_pkg::PH_SEQ: begin
						rx_sum ^= b;
						if (b == next_seq) begin
							seq_q = b;
							rx_stage = sfc_pkg::PH_LEN_HI;
						end else begin
							emit_result(sfc_pkg::KIND_RX_STATUS, b, 16'd0,
								sfc_pkg::STAT_BAD_SEQ);
							rx_stage = sfc_pkg::PH_START;
						end
					end
					sfc_pkg::PH_LEN_HI: begin
						rx_sum ^= b;
						rx_len = {b, 8'h00};
						rx_stage = sfc_pkg::PH_LEN_LO;
					end
					sfc_pkg::PH_LEN_LO: begin
						rx_sum ^= b;
						rx_len[7:0] = b;
						rx_stage = sfc_pkg::PH_TOKEN;
					end
					sfc_pkg::PH_TOKEN: begin
						rx_sum ^= b;
						if (b != sfc_pkg::TOKEN_BYTE) begin
							emit_result(sfc_pkg::KIND_RX_STATUS, b, 16'd0,
								sfc_pkg::STAT_BAD_TOKEN);
							rx_stage = sfc_pkg::PH_START;
						end else begin
							rx_cnt = 16'd0;
							rx_stage = (rx_len == 16'd0) ? sfc_pkg::PH_CHECK
							                             : sfc_pkg::PH_DATA;
						end
					end
					sfc_pkg::PH_DATA: begin
						rx_sum ^= b;
						emit_result(sfc_pkg::KIND_RX_DATA, b, rx_cnt, sfc_pkg::STAT_OK);
						rx_cnt = rx_cnt + 16'd1;
						if (rx_cnt == rx_len)
							rx_stage = sfc_pkg::PH_CHECK;
					end
					default: begin
						emit_result(sfc_pkg::KIND_RX_STATUS, b, 16'd0,
							(b == rx_sum) ? sfc_pkg::STAT_OK : sfc_pkg::STAT_BAD_CHECK);
						rx_stage = sfc_pkg::PH_START;
					end
				endcase
			end
			sfc_pkg::OP_TX_START: begin
				tx_sum = 8'h00;
				emit_tx_line(sfc_pkg::START_BYTE);
				emit_tx_line(seq_q);
				emit_tx_line(len[15:8]);
				emit_tx_line(len[7:0]);
				emit_tx_line(sfc_pkg::TOKEN_BYTE);
				tx_left = len;
				tx_open = (len != 16'd0);
				if (len == 16'd0)
					emit_result(sfc_pkg::KIND_TX_LINE, tx_sum, 16'd0, sfc_pkg::STAT_OK);
			end
			sfc_pkg::OP_TX_BYTE: begin
				if (tx_open) begin
					emit_tx_line(b);
					tx_left = tx_left - 16'd1;
					if (tx_left == 16'd0) begin
						emit_result(sfc_pkg::KIND_TX_LINE, tx_sum, 16'd0, sfc_pkg::STAT_OK);
						tx_open = 1'b0;
					end
				end
			end
			default: ;
		endcase
		// The final word of a burst carries the end-of-run flag.
		if (codec_outputs_due.size() > queued) begin
			w = codec_outputs_due.pop_back();
			w.last = 1'b1;
			codec_outputs_due.push_back(w);
		end
	endfunction

	function automatic logic [7:0] other_than(input logic [7:0] avoid);
		logic [7:0] v;
		do
			v = 8'($urandom);
		while (v == avoid);
		return v;
	endfunction

	// Present one input word, with a random gap first, and wait until it is taken.
	task automatic send_word(input logic [1:0] op, input logic [7:0] b, input logic [15:0] len);
		while (!steady && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		byte_value <= b;
		frame_length <= len;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		compute_codec_outputs(op, b, len);
	endtask

	// A received line byte, optionally preceded by transmit traffic.
	task automatic send_line_byte(input logic [7:0] b, input bit mixed);
		if (mixed && $urandom_range(9) == 0)
			send_word(sfc_pkg::OP_TX_BYTE, 8'($urandom), 16'($urandom));
		send_word(sfc_pkg::OP_RX_BYTE, b, 16'($urandom));
	endtask

	// Feed a received frame; a damaged header ends it at the broken byte.
	task automatic send_rx_frame(input int flaw, input logic [15:0] len, input bit mixed);
		logic [7:0] sum;
		logic [7:0] v;
		int         i;
		v = (flaw == FLAW_START) ? other_than(sfc_pkg::START_BYTE) : sfc_pkg::START_BYTE;
		sum = v;
		send_line_byte(v, mixed);
		if (flaw == FLAW_START)
			return;
		v = seq_q + 8'd1;
		if (flaw == FLAW_SEQ)
			v = other_than(v);
		sum ^= v;
		send_line_byte(v, mixed);
		if (flaw == FLAW_SEQ)
			return;
		sum ^= len[15:8] ^ len[7:0];
		send_line_byte(len[15:8], mixed);
		send_line_byte(len[7:0], mixed);
		v = (flaw == FLAW_TOKEN) ? other_than(sfc_pkg::TOKEN_BYTE) : sfc_pkg::TOKEN_BYTE;
		send_line_byte(v, mixed);
		if (flaw == FLAW_TOKEN)
			return;
		sum ^= v;
		for (i = 0; i < len; i++) begin
			v = 8'($urandom);
			sum ^= v;
			send_line_byte(v, mixed);
		end
		if (flaw == FLAW_CHECK)
			sum ^= 8'($urandom_range(1, 255));
		send_line_byte(sum, mixed);
	endtask

	// Start a transmit frame and pass some of its payload.
	task automatic send_tx_frame(input logic [15:0] len, input int sent);
		int i;
		send_word(sfc_pkg::OP_TX_START, 8'($urandom), len);
		for (i = 0; i < sent; i++)
			send_word(sfc_pkg::OP_TX_BYTE, 8'($urandom), 16'($urandom));
	endtask

	// Hold the input idle until every predicted result word has come out.
	task automatic wait_drained;
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (codec_outputs_due.size() != 0);
	endtask

	// Bytes that are not the start byte while hunting, each with its own status.
	task automatic test_rx_hunting;
		send_word(sfc_pkg::OP_RX_BYTE, 8'h00, 16'h0000);
		send_word(sfc_pkg::OP_RX_BYTE, 8'hFF, 16'hFFFF);
	endtask

	// Good, empty and damaged received frames.
	task automatic test_rx_frames;
		send_rx_frame(FLAW_NONE, 16'd1, 1'b0);
		send_rx_frame(FLAW_NONE, 16'd0, 1'b0);
		send_rx_frame(FLAW_CHECK, 16'd0, 1'b0);
		send_rx_frame(FLAW_SEQ, 16'd0, 1'b0);
		send_rx_frame(FLAW_TOKEN, 16'hFFFF, 1'b0);
	endtask

	// Transmit frames: restart while sending, empty frame, idle payload, unused operation.
	task automatic test_tx_frames;
		send_tx_frame(16'hFFFF, 0);
		send_tx_frame(16'd0, 0);
		send_tx_frame(16'd1, 1);
		send_word(sfc_pkg::OP_TX_BYTE, 8'hFF, 16'hFFFF);
		wait_drained();
		send_word(OP_UNUSED, 8'hA5, 16'h5A5A);
	endtask

	// Mostly well-formed frames in both directions, mixed with noise.
	task automatic test_random_traffic;
		int          base;
		int          pick;
		int          flaw;
		logic [15:0] len;
		base = active_items;
		while (active_items - base < RANDOM_ITEMS) begin
			steady = (active_items - base >= 80) && (active_items - base < 140);
			pick = $urandom_range(99);
			if (pick < 45) begin
				flaw = ($urandom_range(9) < 7) ? FLAW_NONE : $urandom_range(FLAW_START, FLAW_CHECK);
				send_rx_frame(flaw, 16'($urandom_range(0, 6)), 1'b1);
			end else if (pick < 75) begin
				len = 16'($urandom_range(0, 5));
				send_tx_frame(len, ($urandom_range(9) == 0) ? $urandom_range(0, len) : len);
			end else if (pick < 85) begin
				send_word(2'($urandom_range(3)), 8'($urandom), 16'($urandom));
			end else begin
				send_word(sfc_pkg::OP_RX_BYTE, 8'($urandom), 16'($urandom));
			end
		end
		steady = 1'b0;
	endtask

	// Random output stall, off during the steady stretch.
	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < 37);
	end

	// Compare each accepted result word with the oldest prediction.
	always @(posedge clk) begin : check_results
		codec_word_t got;
		codec_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {result_kind, out_byte, payload_index, frame_status, last_of_run};
			if (codec_outputs_due.size() == 0) begin
				note_failure($sformatf("unexpected word: kind %0d byte %02h index %0d status %0d last %0d",
					got.kind, got.data, got.index, got.status, got.last));
			end else begin
				want = codec_outputs_due.pop_front();
				if (got.kind !== want.kind || got.data !== want.data ||
						got.index !== want.index || got.status !== want.status ||
						got.last !== want.last)
					note_failure($sformatf({"word mismatch: expected kind %0d byte %02h index %0d",
						" status %0d last %0d, got kind %0d byte %02h index %0d status %0d last %0d"},
						want.kind, want.data, want.index, want.status, want.last,
						got.kind, got.data, got.index, got.status, got.last));
			end
		end
	end

	// Give up when neither channel has moved for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles <= 0;
		else if (arst_n)
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("serial_frame_codec_xor_checksum_unit test failed");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_rx_hunting();
		test_rx_frames();
		wait_drained();
		test_tx_frames();
		test_random_traffic();
		wait_drained();
		repeat (20) @(posedge clk);
		if (codec_outputs_due.size() != 0)
			note_failure($sformatf("%0d predicted words never came out", codec_outputs_due.size()));
		if (failures == 0)
			$display("serial_frame_codec_xor_checksum_unit test passed");
		else
			$display("serial_frame_codec_xor_checksum_unit test failed");
		$finish;
	end

endmodule
